@@ src/fba_pkg.sv @@
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, constants and helpers for the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int FRAMES_MAX  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = FRAMES_MAX / WORD_BITS;
    localparam int WADDR_W     = $clog2(WORD_COUNT);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WCNT_W      = WADDR_W + 1;
    localparam int FC_W        = 13;
    localparam int FIDX_W      = 12;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int GROUP_BITS  = 16;
    localparam int GROUP_COUNT = WORD_COUNT / GROUP_BITS;
    localparam int GIDX_W      = $clog2(GROUP_BITS);
    localparam int GSEL_W      = $clog2(GROUP_COUNT);

    localparam logic [FC_W-1:0] FRAME_COUNT_RESET = FC_W'(FRAMES_MAX);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TEST  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_OUT_OF_MEM   = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_MODIFY,
        S_DONE,
        S_RECOUNT
    } t_state;

    typedef struct packed {
        logic               found;
        logic [WADDR_W-1:0] word;
    } t_search_res;

    // Whole words under management: frame count limited to the bitmap size,
    // rounded down to a word.
    function automatic logic [WCNT_W-1:0] managed_words(input logic [FC_W-1:0] fc);
        logic [WCNT_W-1:0] w;
        if (fc >= FC_W'(FRAMES_MAX)) begin
            w = WCNT_W'(WORD_COUNT);
        end else begin
            w = WCNT_W'(fc >> BIT_W);
        end
        return w;
    endfunction

endpackage

@@ src/fba_ram.sv @@
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter  int P_WIDTH  = 32,
    parameter  int P_DEPTH  = 128,
    localparam int L_ADDR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [L_ADDR_W-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]  i_wdata,
    input  logic                i_re,
    input  logic [L_ADDR_W-1:0] i_raddr,
    output logic [P_WIDTH-1:0]  o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fba_search.sv @@
// ----------------------------------------------------------------------------
// fba_search
// Two-step search of the word-full vector for the lowest word with a free
// frame: groups are scanned and registered, then the lowest group is picked.
// ----------------------------------------------------------------------------
module fba_search (
    input  logic                            i_clk,
    input  logic                            i_start,
    input  logic [fba_pkg::WORD_COUNT-1:0]  i_full,
    input  logic [fba_pkg::WCNT_W-1:0]      i_words,
    output fba_pkg::t_search_res            o_res
);
    import fba_pkg::*;

    logic [WORD_COUNT-1:0]  w_free;
    logic [GROUP_COUNT-1:0] w_any;
    logic [GIDX_W-1:0]      w_idx [GROUP_COUNT];
    logic [GROUP_COUNT-1:0] r_any;
    logic [GIDX_W-1:0]      r_idx [GROUP_COUNT];

    // Only words inside the managed range may be chosen
    always_comb begin
        for (int i = 0; i < WORD_COUNT; i++) begin
            w_free[i] = !i_full[i] && (WCNT_W'(i) < i_words);
        end
    end

    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            w_any[g] = |w_free[g*GROUP_BITS +: GROUP_BITS];
            w_idx[g] = '0;
            for (int b = GROUP_BITS - 1; b >= 0; b--) begin
                if (w_free[g*GROUP_BITS + b]) begin
                    w_idx[g] = GIDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_any <= w_any;
            r_idx <= w_idx;
        end
    end

    always_comb begin
        o_res.found = 1'b0;
        o_res.word  = '0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                o_res.found = 1'b1;
                o_res.word  = {GSEL_W'(g), r_idx[g]};
            end
        end
    end

endmodule

@@ src/frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// One item at a time is worked on. Allocate steps from acceptance through
// picking the word from the word-full vector and a read-modify-write of the
// bitmap word to the result; free and test skip the pick, and out-of-range
// or no-op items go straight to the result. The bitmap lives in a 128 x 32
// RAM with registered read data; each item reads one word and may write it
// back, and the next item is only taken once that write has happened, so no
// two accesses overlap. A flip-flop per word marks it as written since reset
// and per-word full flags drive the search; reset clears both at once, so
// the block is ready straight after reset. A write to frame_count starts a
// recount of used frames: one RAM word per cycle over the managed words,
// during which no item is taken. The finished result sits in an output
// register, so the next item is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [fba_pkg::FC_W-1:0]      i_cfg_wr_data,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fba_pkg::OP_W-1:0]      i_operation,
    input  logic [fba_pkg::FIDX_W-1:0]    i_frame_index,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fba_pkg::STATUS_W-1:0]  o_status,
    output logic [fba_pkg::FIDX_W-1:0]    o_allocated_frame,
    output logic                          o_frame_in_use,
    output logic [fba_pkg::FC_W-1:0]      o_used_frames,
    output logic [fba_pkg::FC_W-1:0]      o_free_frames
);
    import fba_pkg::*;

    // Count the ones of a word: nibble sums, then a short chain of adds
    function automatic logic [BIT_W:0] pop_word(input logic [WORD_BITS-1:0] w);
        logic [BIT_W:0] s;
        logic [2:0]     c;
        s = '0;
        for (int n = 0; n < WORD_BITS / 4; n++) begin
            c = 3'(w[4*n]) + 3'(w[4*n+1]) + 3'(w[4*n+2]) + 3'(w[4*n+3]);
            s = s + (BIT_W+1)'(c);
        end
        return s;
    endfunction

    // Index of the lowest clear bit of a word
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!w[k]) begin
                idx = BIT_W'(k);
            end
        end
        return idx;
    endfunction

    // Control state
    t_state                r_state, n_state;
    logic [FC_W-1:0]       r_frame_count;
    logic [WORD_COUNT-1:0] r_wvalid;
    logic [WORD_COUNT-1:0] r_full;
    logic [FC_W-1:0]       r_used;
    logic                  r_out_valid;
    logic [WCNT_W-1:0]     r_rc_addr;
    logic                  r_rc_rd;
    logic [WADDR_W-1:0]    r_rc_word;
    logic [FC_W-1:0]       r_rc_acc;

    // Item under work
    t_op                   r_op;
    logic [BIT_W-1:0]      r_bit;
    logic [WADDR_W-1:0]    r_word_addr;
    t_status               r_res_status;
    logic [FIDX_W-1:0]     r_res_alloc;
    logic                  r_res_in_use;

    // Result register
    t_status               r_out_status;
    logic [FIDX_W-1:0]     r_out_alloc;
    logic                  r_out_in_use;
    logic [FC_W-1:0]       r_out_used;
    logic [FC_W-1:0]       r_out_free;

    // Datapath
    logic [WCNT_W-1:0]     w_words;
    logic [FC_W-1:0]       w_managed;
    logic                  w_accept;
    logic                  w_in_range;
    t_search_res           w_search;
    logic                  w_search_start;
    logic                  w_ram_we;
    logic                  w_ram_re;
    logic [WADDR_W-1:0]    w_ram_raddr;
    logic [WORD_BITS-1:0]  w_ram_wdata;
    logic [WORD_BITS-1:0]  w_ram_rdata;
    logic [WORD_BITS-1:0]  w_word;
    logic [WORD_BITS-1:0]  w_rc_data;
    logic [BIT_W-1:0]      w_zero;
    logic [WORD_BITS-1:0]  w_alloc_word;
    logic [WORD_BITS-1:0]  w_free_word;
    logic                  w_bit;
    logic                  w_out_slot;
    logic                  w_rc_issue;

    assign w_words    = managed_words(r_frame_count);
    assign w_managed  = {w_words, BIT_W'(0)};
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = {1'b0, i_frame_index} < w_managed;
    assign w_out_slot = !r_out_valid || i_ready;
    assign w_rc_issue = r_rc_addr < w_words;

    // Words never written since reset read as all free
    assign w_word       = r_wvalid[r_word_addr] ? w_ram_rdata : '0;
    assign w_rc_data    = r_wvalid[r_rc_word] ? w_ram_rdata : '0;
    assign w_zero       = lowest_zero(w_word);
    assign w_alloc_word = w_word | (WORD_BITS'(1) << w_zero);
    assign w_free_word  = w_word & ~(WORD_BITS'(1) << r_bit);
    assign w_bit        = w_word[r_bit];
    assign w_ram_wdata  = (r_op == OP_ALLOC) ? w_alloc_word : w_free_word;

    fba_search u_search (
        .i_clk   (i_clk),
        .i_start (w_search_start),
        .i_full  (r_full),
        .i_words (w_words),
        .o_res   (w_search)
    );

    fba_ram #(
        .P_WIDTH (WORD_BITS),
        .P_DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_word_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_operation)) inside
                        OP_ALLOC:         n_state = S_PICK;
                        OP_FREE, OP_TEST: n_state = w_in_range ? S_MODIFY : S_DONE;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_PICK:    n_state = w_search.found ? S_MODIFY : S_DONE;
            S_MODIFY:  n_state = S_DONE;
            S_DONE:    n_state = w_out_slot ? S_IDLE : S_DONE;
            S_RECOUNT: n_state = (!w_rc_issue && !r_rc_rd) ? S_IDLE : S_RECOUNT;
            default:   n_state = S_IDLE;
        endcase
        // A frame_count write always restarts the recount
        if (i_cfg_wr_en) begin
            n_state = S_RECOUNT;
        end
    end

    // Outputs of the state machine
    always_comb begin
        o_ready        = 1'b0;
        w_search_start = 1'b0;
        w_ram_re       = 1'b0;
        w_ram_raddr    = '0;
        w_ram_we       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready        = !i_cfg_wr_en;
                w_search_start = 1'b1;
                w_ram_re       = 1'b1;
                w_ram_raddr    = i_frame_index[FIDX_W-1 -: WADDR_W];
            end
            S_PICK: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_search.word;
            end
            S_MODIFY: begin
                w_ram_we = (r_op == OP_ALLOC) || ((r_op == OP_FREE) && w_bit);
            end
            S_RECOUNT: begin
                w_ram_re    = w_rc_issue;
                w_ram_raddr = r_rc_addr[WADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= FRAME_COUNT_RESET;
            r_wvalid      <= '0;
            r_full        <= '0;
            r_used        <= '0;
            r_out_valid   <= 1'b0;
            r_rc_addr     <= '0;
            r_rc_rd       <= 1'b0;
            r_rc_acc      <= '0;
        end else begin
            r_state <= n_state;

            if (w_ram_we) begin
                r_wvalid[r_word_addr] <= 1'b1;
                r_full[r_word_addr]   <= (r_op == OP_ALLOC) ? &w_alloc_word : 1'b0;
                r_used <= (r_op == OP_ALLOC) ? r_used + FC_W'(1) : r_used - FC_W'(1);
            end

            // Load the next result when the slot frees, else drop it once taken
            if (r_state == S_DONE && w_out_slot) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                r_frame_count <= i_cfg_wr_data;
                r_rc_addr     <= '0;
                r_rc_rd       <= 1'b0;
                r_rc_acc      <= '0;
            end else if (r_state == S_RECOUNT) begin
                // Recount: issue one read a cycle, add its ones in the cycle after
                if (w_rc_issue) begin
                    r_rc_addr <= r_rc_addr + WCNT_W'(1);
                end
                r_rc_rd <= w_rc_issue;
                if (r_rc_rd) begin
                    r_rc_acc <= r_rc_acc + FC_W'(pop_word(w_rc_data));
                end
                if (!w_rc_issue && !r_rc_rd) begin
                    r_used <= r_rc_acc;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rc_word <= r_rc_addr[WADDR_W-1:0];

        if (w_accept) begin
            r_op         <= t_op'(i_operation);
            r_bit        <= i_frame_index[BIT_W-1:0];
            r_word_addr  <= i_frame_index[FIDX_W-1 -: WADDR_W];
            r_res_alloc  <= '0;
            r_res_in_use <= 1'b0;
            case (t_op'(i_operation)) inside
                OP_FREE, OP_TEST: r_res_status <= w_in_range ? ST_OK : ST_OUT_OF_RANGE;
                default:          r_res_status <= ST_OK;
            endcase
        end

        if (r_state == S_PICK) begin
            r_word_addr <= w_search.word;
            if (!w_search.found) begin
                r_res_status <= ST_OUT_OF_MEM;
            end
        end

        if (r_state == S_MODIFY) begin
            case (r_op)
                OP_ALLOC: r_res_alloc <= {r_word_addr, w_zero};
                OP_FREE: begin
                    r_res_in_use <= w_bit;
                    if (!w_bit) begin
                        r_res_status <= ST_ALREADY_FREE;
                    end
                end
                OP_TEST:  r_res_in_use <= w_bit;
                default: begin
                end
            endcase
        end

        if (r_state == S_DONE && w_out_slot) begin
            r_out_status <= r_res_status;
            r_out_alloc  <= r_res_alloc;
            r_out_in_use <= r_res_in_use;
            r_out_used   <= r_used;
            r_out_free   <= w_managed - r_used;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_allocated_frame = r_out_alloc;
    assign o_frame_in_use    = r_out_in_use;
    assign o_used_frames     = r_out_used;
    assign o_free_frames     = r_out_free;

endmodule

@@ src/fba_checker.sv @@
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks on the frame bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fba_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [fba_pkg::STATUS_W-1:0]  o_status,
    input  logic [fba_pkg::FIDX_W-1:0]    o_allocated_frame,
    input  logic                          o_frame_in_use,
    input  logic [fba_pkg::FC_W-1:0]      o_used_frames,
    input  logic [fba_pkg::FC_W-1:0]      o_free_frames
);
    import fba_pkg::*;

    logic [1:0]    r_outstanding;
    logic [FC_W:0] w_total;

    assign w_total = {1'b0, o_used_frames} + {1'b0, o_free_frames};

    // Items taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 2'(i_valid && o_ready)
                                           - 2'(o_valid && i_ready);
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
                               && $stable(o_allocated_frame) && $stable(o_used_frames))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_outstanding != 2'd0 && r_outstanding <= 2'd2)
        else $error("result without a matching item");

    a_clean_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_allocated_frame == '0)
        else $error("failed item reports a frame");

    a_no_inuse_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ALREADY_FREE || o_status == ST_OUT_OF_RANGE)
        |-> !o_frame_in_use)
        else $error("frame in use flagged on a rejected frame");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_total[BIT_W-1:0] == '0 && w_total <= (FC_W+1)'(FRAMES_MAX))
        else $error("used and free counts do not cover whole words");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);
